/* src/slrl_pkg.sv */
// Shared types, constants and register map of the sliding-log rate limiter.
package slrl_pkg;

    localparam int SLRL_LOG_DEPTH = 64;
    localparam int SLRL_TIME_BITS = 32;

    localparam int CFG_TIME_W = 31;
    localparam int CFG_LIM_W  = 7;
    localparam int COUNT_W    = 7;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [2:0] REG_WINDOW       = 3'd1;
    localparam logic [2:0] REG_BURST        = 3'd2;
    localparam logic [2:0] REG_WINDOW_LIMIT = 3'd3;
    localparam logic [2:0] REG_BURST_LIMIT  = 3'd4;

    localparam logic [CFG_TIME_W-1:0] RST_MIN_INTERVAL = 31'd1000;
    localparam logic [CFG_TIME_W-1:0] RST_WINDOW       = 31'd20000;
    localparam logic [CFG_TIME_W-1:0] RST_BURST        = 31'd5000;
    localparam logic [CFG_LIM_W-1:0]  RST_WINDOW_LIMIT = 7'd5;
    localparam logic [CFG_LIM_W-1:0]  RST_BURST_LIMIT  = 7'd3;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    localparam logic [2:0] VERDICT_GRANTED     = 3'd0;
    localparam logic [2:0] VERDICT_INTERVAL    = 3'd1;
    localparam logic [2:0] VERDICT_WINDOW_FULL = 3'd2;
    localparam logic [2:0] VERDICT_BURST_FULL  = 3'd3;
    localparam logic [2:0] VERDICT_RECORDED    = 3'd4;

    typedef struct packed {
        logic [CFG_TIME_W-1:0] min_interval_ticks;
        logic [CFG_TIME_W-1:0] window_ticks;
        logic [CFG_TIME_W-1:0] burst_ticks;
        logic [CFG_LIM_W-1:0]  window_limit;
        logic [CFG_LIM_W-1:0]  burst_limit;
    } slrl_cfg_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic reply;
        logic record;
    } slrl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } slrl_sts_t;

endpackage

/* src/slrl_regs.sv */
// APB configuration registers of the rate limiter.
module slrl_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [slrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [slrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output slrl_pkg::slrl_cfg_t               cfg
);
    import slrl_pkg::*;

    slrl_cfg_t  cfg_reg;
    slrl_cfg_t  cfg_next;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_MIN_INTERVAL: cfg_next.min_interval_ticks = pwdata[CFG_TIME_W-1:0];
                REG_WINDOW:       cfg_next.window_ticks       = pwdata[CFG_TIME_W-1:0];
                REG_BURST:        cfg_next.burst_ticks        = pwdata[CFG_TIME_W-1:0];
                REG_WINDOW_LIMIT: cfg_next.window_limit       = pwdata[CFG_LIM_W-1:0];
                REG_BURST_LIMIT:  cfg_next.burst_limit        = pwdata[CFG_LIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MIN_INTERVAL: prdata = APB_DATA_W'(cfg_reg.min_interval_ticks);
            REG_WINDOW:       prdata = APB_DATA_W'(cfg_reg.window_ticks);
            REG_BURST:        prdata = APB_DATA_W'(cfg_reg.burst_ticks);
            REG_WINDOW_LIMIT: prdata = APB_DATA_W'(cfg_reg.window_limit);
            REG_BURST_LIMIT:  prdata = APB_DATA_W'(cfg_reg.burst_limit);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_interval_ticks <= RST_MIN_INTERVAL;
            cfg_reg.window_ticks       <= RST_WINDOW;
            cfg_reg.burst_ticks        <= RST_BURST;
            cfg_reg.window_limit       <= RST_WINDOW_LIMIT;
            cfg_reg.burst_limit        <= RST_BURST_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/slrl_ctrl.sv */
// Controller state machine: sequences load, log scan, reply and record.
module slrl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 opcode,
    output logic                 busy,
    output slrl_pkg::slrl_cmd_t  cmd,
    input  slrl_pkg::slrl_sts_t  sts
);
    import slrl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_REPLY = 4'b0100,
        ST_REC   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (opcode == OP_RECORD) ? ST_REC : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                cmd.reply  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_REC:
            begin
                cmd.record = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/slrl_dp.sv */
// Datapath: time log memory, pointers, scan pipeline and result registers.
module slrl_dp
#(
    parameter int LOG_DEPTH = slrl_pkg::SLRL_LOG_DEPTH,
    parameter int TIME_BITS = slrl_pkg::SLRL_TIME_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [TIME_BITS-1:0]              now_ticks,
    input  slrl_pkg::slrl_cfg_t               cfg,
    input  slrl_pkg::slrl_cmd_t               cmd,
    output slrl_pkg::slrl_sts_t               sts,
    output logic                              done,
    output logic                              granted,
    output logic [2:0]                        verdict,
    output logic [slrl_pkg::COUNT_W-1:0]      logged_count,
    output logic [slrl_pkg::COUNT_W-1:0]      recent_count,
    output logic                              dropped_oldest
);
    import slrl_pkg::*;

    localparam int IDX_W = $clog2(LOG_DEPTH);
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    logic [TIME_BITS-1:0] mem [LOG_DEPTH];
    logic [TIME_BITS-1:0] rdata_reg;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;

    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] last_reg,     last_next;
    logic                 ever_reg,     ever_next;
    logic [IDX_W-1:0]     head_reg,     head_next;
    logic [CNT_W-1:0]     fill_reg,     fill_next;
    logic [IDX_W-1:0]     rd_idx_reg,   rd_idx_next;
    logic [CNT_W-1:0]     rd_left_reg,  rd_left_next;
    logic                 vld_reg,      vld_next;
    logic                 clean_reg,    clean_next;
    logic [CNT_W-1:0]     cnt_reg,      cnt_next;
    logic                 done_reg;

    logic                 granted_reg,  granted_next;
    logic [2:0]           verdict_reg,  verdict_next;
    logic [COUNT_W-1:0]   logged_reg,   logged_next;
    logic [COUNT_W-1:0]   recent_reg,   recent_next;
    logic                 dropped_reg,  dropped_next;

    logic [TIME_BITS-1:0] age_entry;
    logic [TIME_BITS-1:0] age_last;
    logic                 expired;
    logic                 in_burst;
    logic                 too_soon;
    logic                 log_full;
    logic [IDX_W:0]       wr_sum;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == IDX_W'(LOG_DEPTH - 1)) ? '0 : idx + 1'b1;
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [COUNT_W-1:0] res;
        res = (32'(v) > 32'd127) ? COUNT_W'(127) : COUNT_W'(v);
        return res;
    endfunction

    assign age_entry = now_reg - rdata_reg;
    assign age_last  = now_reg - last_reg;
    assign expired   = CMP_W'(age_entry) > CMP_W'(cfg.window_ticks);
    assign in_burst  = CMP_W'(age_entry) <= CMP_W'(cfg.burst_ticks);
    assign too_soon  = ever_reg && (CMP_W'(age_last) < CMP_W'(cfg.min_interval_ticks));
    assign log_full  = (fill_reg == CNT_W'(LOG_DEPTH));

    assign wr_sum = (IDX_W + 1)'(head_reg) + (IDX_W + 1)'(fill_reg);
    assign wr_idx = log_full ? head_reg
                  : (wr_sum >= (IDX_W + 1)'(LOG_DEPTH))
                    ? IDX_W'(wr_sum - (IDX_W + 1)'(LOG_DEPTH))
                    : IDX_W'(wr_sum);

    assign rd_en = cmd.scan && (rd_left_reg != '0);
    assign wr_en = cmd.record;

    assign sts.scan_done = (rd_left_reg == '0) && !vld_reg;

    always_comb
    begin
        last_next    = last_reg;
        ever_next    = ever_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        rd_idx_next  = rd_idx_reg;
        rd_left_next = rd_left_reg;
        vld_next     = 1'b0;
        clean_next   = clean_reg;
        cnt_next     = cnt_reg;
        granted_next = granted_reg;
        verdict_next = verdict_reg;
        logged_next  = logged_reg;
        recent_next  = recent_reg;
        dropped_next = dropped_reg;

        if (cmd.load)
        begin
            rd_idx_next  = head_reg;
            rd_left_next = fill_reg;
            clean_next   = 1'b1;
            cnt_next     = '0;
        end

        if (cmd.scan)
        begin
            if (rd_en)
            begin
                rd_idx_next  = wrap_inc(rd_idx_reg);
                rd_left_next = rd_left_reg - 1'b1;
                vld_next     = 1'b1;
            end
            if (vld_reg)
            begin
                if (clean_reg && expired)
                begin
                    head_next = wrap_inc(head_reg);
                    fill_next = fill_reg - 1'b1;
                end
                else
                begin
                    clean_next = 1'b0;
                    if (in_burst)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
        end

        if (cmd.reply)
        begin
            dropped_next = 1'b0;
            logged_next  = sat_count(fill_reg);
            recent_next  = sat_count(cnt_reg);
            granted_next = 1'b0;
            if (too_soon)
            begin
                verdict_next = VERDICT_INTERVAL;
            end
            else if (32'(fill_reg) >= 32'(cfg.window_limit))
            begin
                verdict_next = VERDICT_WINDOW_FULL;
            end
            else if (32'(cnt_reg) >= 32'(cfg.burst_limit))
            begin
                verdict_next = VERDICT_BURST_FULL;
            end
            else
            begin
                verdict_next = VERDICT_GRANTED;
                granted_next = 1'b1;
            end
        end

        if (cmd.record)
        begin
            if (log_full)
            begin
                head_next = wrap_inc(head_reg);
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
            last_next    = now_reg;
            ever_next    = 1'b1;
            granted_next = 1'b0;
            verdict_next = VERDICT_RECORDED;
            logged_next  = log_full ? sat_count(fill_reg) : sat_count(fill_reg + 1'b1);
            recent_next  = '0;
            dropped_next = log_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= now_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_ticks;
        end
        rd_idx_reg  <= rd_idx_next;
        granted_reg <= granted_next;
        verdict_reg <= verdict_next;
        logged_reg  <= logged_next;
        recent_reg  <= recent_next;
        dropped_reg <= dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= '0;
            ever_reg    <= 1'b0;
            head_reg    <= '0;
            fill_reg    <= '0;
            rd_left_reg <= '0;
            vld_reg     <= 1'b0;
            clean_reg   <= 1'b0;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            last_reg    <= last_next;
            ever_reg    <= ever_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            rd_left_reg <= rd_left_next;
            vld_reg     <= vld_next;
            clean_reg   <= clean_next;
            cnt_reg     <= cnt_next;
            done_reg    <= cmd.reply || cmd.record;
        end
    end

    assign done           = done_reg;
    assign granted        = granted_reg;
    assign verdict        = verdict_reg;
    assign logged_count   = logged_reg;
    assign recent_count   = recent_reg;
    assign dropped_oldest = dropped_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= LOG_DEPTH)
        else $error("log fill above depth");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fill_reg)
        else $error("burst count above log fill");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> $past(cmd.scan))
        else $error("log word valid outside a scan");

endmodule

/* src/sliding_log_rate_limiter.sv */
// Top level of the sliding-log rate limiter.
//
//  channel   direction  signals                                   accepted when
//  command   in         start, opcode, now_ticks / busy           start && !busy
//  result    out        done, granted, verdict, logged_count,     done (one cycle)
//                       recent_count, dropped_oldest
//  config    in         psel, penable, pwrite, paddr, pwdata /    psel && penable && pwrite
//                       prdata, pready
//
// A record word passes through the record state before its result strobe is registered.
// A query walks the log through one memory read port, one entry per cycle:
// its result strobe is registered after the scan state has read every logged
// entry and the reply state has set the verdict, also when the log is empty.
// busy is low again in the strobe cycle, so the next word can be taken then.
// Reset empties the log and loads the default register values at once.
// Results cannot be held off by the receiver.
module sliding_log_rate_limiter
#(
    parameter int LOG_DEPTH = slrl_pkg::SLRL_LOG_DEPTH,
    parameter int TIME_BITS = slrl_pkg::SLRL_TIME_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              opcode,
    input  logic [TIME_BITS-1:0]              now_ticks,
    output logic                              done,
    output logic                              granted,
    output logic [2:0]                        verdict,
    output logic [slrl_pkg::COUNT_W-1:0]      logged_count,
    output logic [slrl_pkg::COUNT_W-1:0]      recent_count,
    output logic                              dropped_oldest,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slrl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [slrl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [slrl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import slrl_pkg::*;

    slrl_cfg_t cfg;
    slrl_cmd_t cmd;
    slrl_sts_t sts;

    slrl_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slrl_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .busy   (busy),
        .cmd    (cmd),
        .sts    (sts)
    );

    slrl_dp
    #(
        .LOG_DEPTH (LOG_DEPTH),
        .TIME_BITS (TIME_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .now_ticks      (now_ticks),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .done           (done),
        .granted        (granted),
        .verdict        (verdict),
        .logged_count   (logged_count),
        .recent_count   (recent_count),
        .dropped_oldest (dropped_oldest)
    );

endmodule
